@@ rtl/m3i_pkg.sv @@
package m3i_pkg;

  localparam int DATA_W       = 16;
  localparam int PROD_W       = 2 * DATA_W;
  localparam int COF_W        = PROD_W + 1;
  localparam int DPROD_W      = DATA_W + COF_W;
  localparam int DET_W        = DPROD_W + 1;
  localparam int DEN_W        = DET_W - 1;
  localparam int MAG_W        = COF_W - 1;
  localparam int Q_W          = 32;
  localparam int FRAC_SH      = 24;
  localparam int LO_BITS      = Q_W - FRAC_SH;
  localparam int REM_W        = DEN_W + 1;
  localparam int NLANE        = 9;
  localparam int DIV_STEPS    = Q_W;
  localparam int FRONT_STAGES = 5;
  localparam int LANE_STAGES  = DIV_STEPS + 1;
  localparam int NSTG         = FRONT_STAGES + LANE_STAGES + 1;

  localparam logic [Q_W-1:0] SAT_POS = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] SAT_NEG = {1'b1, {(Q_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] entry_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic        [Q_W-1:0]    quo_t;

  typedef struct packed {
    entry_t m00; entry_t m01; entry_t m02;
    entry_t m10; entry_t m11; entry_t m12;
    entry_t m20; entry_t m21; entry_t m22;
  } mat_t;

  typedef struct packed {
    logic signed [Q_W-1:0] r00; logic signed [Q_W-1:0] r01; logic signed [Q_W-1:0] r02;
    logic signed [Q_W-1:0] r10; logic signed [Q_W-1:0] r11; logic signed [Q_W-1:0] r12;
    logic signed [Q_W-1:0] r20; logic signed [Q_W-1:0] r21; logic signed [Q_W-1:0] r22;
    logic                  singular;
  } res_t;

  // Per-lane status handed from a divider lane to the merging stage.
  typedef struct packed {
    logic neg;
    logic ovf;
    logic zero;
  } lane_flags_t;

endpackage

@@ rtl/m3i_chan.sv @@
interface m3i_chan #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/m3i_front.sv @@
module m3i_front (
  input  logic                clk,
  input  logic [m3i_pkg::FRONT_STAGES-1:0] en,
  input  m3i_pkg::mat_t       mat_in,
  output m3i_pkg::cof_t       cof [m3i_pkg::NLANE],
  output m3i_pkg::det_t       det
);

  m3i_pkg::mat_t m;

  logic signed [m3i_pkg::PROD_W-1:0]  pa [m3i_pkg::NLANE];
  logic signed [m3i_pkg::PROD_W-1:0]  pb [m3i_pkg::NLANE];
  m3i_pkg::entry_t                    c1 [3];
  m3i_pkg::cof_t                      cf2 [m3i_pkg::NLANE];
  m3i_pkg::entry_t                    c2 [3];
  logic signed [m3i_pkg::DPROD_W-1:0] dp [3];
  m3i_pkg::cof_t                      cf3 [m3i_pkg::NLANE];
  m3i_pkg::cof_t                      cf4 [m3i_pkg::NLANE];
  m3i_pkg::det_t                      det4;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m <= mat_in;
    end
  end

  // Cofactor (i,j) sits at index i*3+j and is pa - pb.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      pa[0] <= m.m11 * m.m22;  pb[0] <= m.m21 * m.m12;
      pa[1] <= m.m12 * m.m20;  pb[1] <= m.m22 * m.m10;
      pa[2] <= m.m10 * m.m21;  pb[2] <= m.m20 * m.m11;
      pa[3] <= m.m21 * m.m02;  pb[3] <= m.m01 * m.m22;
      pa[4] <= m.m22 * m.m00;  pb[4] <= m.m02 * m.m20;
      pa[5] <= m.m20 * m.m01;  pb[5] <= m.m00 * m.m21;
      pa[6] <= m.m01 * m.m12;  pb[6] <= m.m11 * m.m02;
      pa[7] <= m.m02 * m.m10;  pb[7] <= m.m12 * m.m00;
      pa[8] <= m.m00 * m.m11;  pb[8] <= m.m10 * m.m01;
      c1[0] <= m.m00;
      c1[1] <= m.m10;
      c1[2] <= m.m20;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < m3i_pkg::NLANE; k++) begin
        cf2[k] <= m3i_pkg::COF_W'(pa[k]) - m3i_pkg::COF_W'(pb[k]);
      end
      c2 <= c1;
    end
  end

  // Determinant by expansion down column 0.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        dp[k] <= c2[k] * cf2[k*3];
      end
      cf3 <= cf2;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      det4 <= m3i_pkg::DET_W'(dp[0]) + m3i_pkg::DET_W'(dp[1]) + m3i_pkg::DET_W'(dp[2]);
      cf4  <= cf3;
    end
  end

  assign cof = cf4;
  assign det = det4;

endmodule

@@ rtl/m3i_lane.sv @@
module m3i_lane (
  input  logic                              clk,
  input  logic [m3i_pkg::LANE_STAGES-1:0]   en,
  input  m3i_pkg::cof_t                     cof,
  input  m3i_pkg::det_t                     det,
  output m3i_pkg::quo_t                     quo,
  output m3i_pkg::lane_flags_t              flags
);

  localparam int NS = m3i_pkg::LANE_STAGES;

  logic [m3i_pkg::REM_W-1:0] rem [NS];
  logic [m3i_pkg::Q_W-1:0]   lo  [NS];
  logic [m3i_pkg::Q_W-1:0]   q   [NS];
  logic [m3i_pkg::DEN_W-1:0] den [NS];
  m3i_pkg::lane_flags_t      fl  [NS];

  logic [m3i_pkg::COF_W-1:0] cabs;
  logic [m3i_pkg::DET_W-1:0] dabs;
  logic [m3i_pkg::MAG_W-1:0] mag;
  logic [m3i_pkg::DEN_W-1:0] dmag;

  always_comb begin
    cabs = cof[m3i_pkg::COF_W-1] ? -cof : cof;
    dabs = det[m3i_pkg::DET_W-1] ? -det : det;
    mag  = cabs[m3i_pkg::MAG_W-1:0];
    dmag = dabs[m3i_pkg::DEN_W-1:0];
  end

  // Set-up stage. The numerator is mag * 2^24; its part above bit 31 seeds the
  // remainder. A quotient of 2^32 or more is flagged here and saturates later.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0]     <= m3i_pkg::REM_W'(mag[m3i_pkg::MAG_W-1:m3i_pkg::LO_BITS]);
      lo[0]      <= {mag[m3i_pkg::LO_BITS-1:0], {m3i_pkg::FRAC_SH{1'b0}}};
      q[0]       <= '0;
      den[0]     <= dmag;
      fl[0].neg  <= cof[m3i_pkg::COF_W-1] ^ det[m3i_pkg::DET_W-1];
      fl[0].ovf  <= {{m3i_pkg::DEN_W{1'b0}}, mag} >= {dmag, {m3i_pkg::MAG_W{1'b0}}} >> (m3i_pkg::MAG_W - m3i_pkg::LO_BITS);
      fl[0].zero <= (dmag == '0);
    end
  end

  // One quotient bit per stage, restoring division.
  for (genvar s = 1; s < NS; s++) begin : g_step
    logic [m3i_pkg::REM_W-1:0] trial;
    logic                      ge;

    always_comb begin
      trial = {rem[s-1][m3i_pkg::REM_W-2:0], lo[s-1][m3i_pkg::Q_W-1]};
      ge    = trial >= {1'b0, den[s-1]};
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem[s] <= ge ? trial - {1'b0, den[s-1]} : trial;
        lo[s]  <= {lo[s-1][m3i_pkg::Q_W-2:0], 1'b0};
        q[s]   <= {q[s-1][m3i_pkg::Q_W-2:0], ge};
        den[s] <= den[s-1];
        fl[s]  <= fl[s-1];
      end
    end
  end

  assign quo   = q[NS-1];
  assign flags = fl[NS-1];

endmodule

@@ rtl/m3i_merge.sv @@
module m3i_merge (
  input  logic                 clk,
  input  logic                 en,
  input  m3i_pkg::quo_t        quo   [m3i_pkg::NLANE],
  input  m3i_pkg::lane_flags_t flags [m3i_pkg::NLANE],
  output m3i_pkg::res_t        res
);

  logic [m3i_pkg::Q_W-1:0] r [m3i_pkg::NLANE];
  logic                    sing;
  m3i_pkg::res_t           res_q;

  always_comb begin
    sing = flags[0].zero;
    for (int k = 0; k < m3i_pkg::NLANE; k++) begin
      if (sing) begin
        r[k] = '0;
      end else if (flags[k].neg) begin
        r[k] = (flags[k].ovf || quo[k] > m3i_pkg::SAT_NEG) ? m3i_pkg::SAT_NEG : -quo[k];
      end else begin
        r[k] = (flags[k].ovf || quo[k][m3i_pkg::Q_W-1]) ? m3i_pkg::SAT_POS : quo[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_q.r00      <= r[0];
      res_q.r01      <= r[1];
      res_q.r02      <= r[2];
      res_q.r10      <= r[3];
      res_q.r11      <= r[4];
      res_q.r12      <= r[5];
      res_q.r20      <= r[6];
      res_q.r21      <= r[7];
      res_q.r22      <= r[8];
      res_q.singular <= sing;
    end
  end

  assign res = res_q;

endmodule

@@ rtl/matrix3_inverse.sv @@
// 3x3 matrix inverse by the adjugate. One Q8.8 matrix is taken per cycle unless
// a held output has filled every stage, and one Q16.16 result leaves for each.
// The front stages form the products, cofactors and determinant, nine divider
// lanes each have a set-up stage and a one-bit-per-stage restoring divider, and a
// final register saturates, signs and merges the lanes. A held output stalls only
// the occupied stages behind it, so empty stages keep taking new matrices.
module matrix3_inverse (
  input logic     clk,
  input logic     rst,
  m3i_chan.sink   mat,
  m3i_chan.source inv
);

  localparam int NS = m3i_pkg::NSTG;
  localparam int FS = m3i_pkg::FRONT_STAGES;
  localparam int LS = m3i_pkg::LANE_STAGES;

  logic [NS-1:0] v;
  logic [NS-1:0] load;

  m3i_pkg::cof_t        cof   [m3i_pkg::NLANE];
  m3i_pkg::det_t        det;
  m3i_pkg::quo_t        quo   [m3i_pkg::NLANE];
  m3i_pkg::lane_flags_t flags [m3i_pkg::NLANE];
  m3i_pkg::res_t        res;

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    load[NS-1] = !v[NS-1] || inv.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      load[k] = !v[k] || load[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (load[0]) begin
        v[0] <= mat.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (load[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign mat.ready = load[0];
  assign inv.valid = v[NS-1];
  assign inv.data  = res;

  m3i_front u_front (
    .clk    (clk),
    .en     (load[FS-1:0]),
    .mat_in (mat.data),
    .cof    (cof),
    .det    (det)
  );

  // Output entry (r,c) divides cofactor (c,r).
  for (genvar l = 0; l < m3i_pkg::NLANE; l++) begin : g_lane
    m3i_lane u_lane (
      .clk   (clk),
      .en    (load[FS+LS-1:FS]),
      .cof   (cof[(l % 3) * 3 + (l / 3)]),
      .det   (det),
      .quo   (quo[l]),
      .flags (flags[l])
    );
  end

  m3i_merge u_merge (
    .clk   (clk),
    .en    (load[NS-1]),
    .quo   (quo),
    .flags (flags),
    .res   (res)
  );

endmodule

@@ rtl/m3i_check.sv @@
module m3i_check (
  input logic          clk,
  input logic          rst,
  input logic          inv_valid,
  input logic          inv_ready,
  input m3i_pkg::res_t inv_data
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    inv_valid && !inv_ready |=> inv_valid)
    else $error("result withdrawn before its transfer");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    inv_valid && !inv_ready |=> $stable(inv_data))
    else $error("stalled result changed");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    inv_valid && inv_data.singular |->
      inv_data.r00 == 0 && inv_data.r01 == 0 && inv_data.r02 == 0 &&
      inv_data.r10 == 0 && inv_data.r11 == 0 && inv_data.r12 == 0 &&
      inv_data.r20 == 0 && inv_data.r21 == 0 && inv_data.r22 == 0)
    else $error("singular result with nonzero entries");

  a_reset_empty: assert property (@(posedge clk) rst |=> !inv_valid)
    else $error("result shown straight after reset");

endmodule

bind matrix3_inverse m3i_check u_check (
  .clk       (clk),
  .rst       (rst),
  .inv_valid (inv.valid),
  .inv_ready (inv.ready),
  .inv_data  (inv.data)
);

@@ tb/m3i_inverse_checker.sv @@
`timescale 1ns / 100ps

module m3i_inverse_checker (
  input  logic    clk,
  input  logic    rst,
  m3i_chan.sink   mat,
  m3i_chan.sink   inv,
  output int      fail_count,
  output int      pending
);

  m3i_pkg::res_t expected_q[$];

  // Entry = (cofactor * 2^24) / det, truncated toward zero and clipped to 32 bits.
  function automatic logic signed [31:0] scaled_quotient(longint cof, longint det);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    logic         neg;
    neg = (cof < 0) != (det < 0);
    num = (cof < 0) ? 128'(-cof) : 128'(cof);
    num = num << 24;
    den = (det < 0) ? 128'(-det) : 128'(det);
    q = num / den;
    if (neg) begin
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      return -$signed(q[31:0]);
    end
    if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic m3i_pkg::res_t invert_matrix(m3i_pkg::mat_t m);
    longint        a [3][3];
    longint        cf [3][3];
    longint        det;
    m3i_pkg::res_t r;
    a[0][0] = m.m00; a[0][1] = m.m01; a[0][2] = m.m02;
    a[1][0] = m.m10; a[1][1] = m.m11; a[1][2] = m.m12;
    a[2][0] = m.m20; a[2][1] = m.m21; a[2][2] = m.m22;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cf[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
                 - a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
      end
    end
    det = a[0][0] * cf[0][0] + a[1][0] * cf[1][0] + a[2][0] * cf[2][0];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    r.r00 = scaled_quotient(cf[0][0], det);
    r.r01 = scaled_quotient(cf[1][0], det);
    r.r02 = scaled_quotient(cf[2][0], det);
    r.r10 = scaled_quotient(cf[0][1], det);
    r.r11 = scaled_quotient(cf[1][1], det);
    r.r12 = scaled_quotient(cf[2][1], det);
    r.r20 = scaled_quotient(cf[0][2], det);
    r.r21 = scaled_quotient(cf[1][2], det);
    r.r22 = scaled_quotient(cf[2][2], det);
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    m3i_pkg::res_t want;
    m3i_pkg::res_t got;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (mat.valid && mat.ready) expected_q.push_back(invert_matrix(mat.data));
      if (inv.valid && inv.ready) begin
        got = inv.data;
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transfer: %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("inverse mismatch at %0t:", $realtime);
              $display("  exp %0d %0d %0d / %0d %0d %0d / %0d %0d %0d sing %b",
                       want.r00, want.r01, want.r02, want.r10, want.r11, want.r12,
                       want.r20, want.r21, want.r22, want.singular);
              $display("  got %0d %0d %0d / %0d %0d %0d / %0d %0d %0d sing %b",
                       got.r00, got.r01, got.r02, got.r10, got.r11, got.r12,
                       got.r20, got.r21, got.r22, got.singular);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/matrix3_inverse_tb.sv @@
`timescale 1ns / 100ps

module matrix3_inverse_tb;

  localparam int RANDOM_ITEMS = 1430;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  bit   quiet_phase = 1'b0;
  bit   long_hold = 1'b0;

  m3i_chan #(.T(m3i_pkg::mat_t)) mat ();
  m3i_chan #(.T(m3i_pkg::res_t)) inv ();

  matrix3_inverse dut (.clk(clk), .rst(rst), .mat(mat), .inv(inv));

  m3i_inverse_checker chk (
    .clk(clk), .rst(rst), .mat(mat), .inv(inv),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [15:0] pick_entry();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(0, 8)) - 4);
      3: return $urandom_range(0, 1) ? 16'h0100 : 16'hFF00;
      4: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic m3i_pkg::mat_t random_matrix();
    m3i_pkg::mat_t m;
    m = {pick_entry(), pick_entry(), pick_entry(), pick_entry(), pick_entry(),
         pick_entry(), pick_entry(), pick_entry(), pick_entry()};
    // Now and then force a singular matrix by repeating or zeroing a row.
    case ($urandom_range(0, 7))
      0: begin m.m20 = m.m00; m.m21 = m.m01; m.m22 = m.m02; end
      1: begin m.m10 = 0; m.m11 = 0; m.m12 = 0; end
      default: ;
    endcase
    return m;
  endfunction

  task automatic send_matrix(m3i_pkg::mat_t m);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      mat.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mat.valid <= 1'b1;
    mat.data  <= m;
    @(posedge clk);
    while (!mat.ready) @(posedge clk);
  endtask

  // Receiver side: random stalls, one long hold-off, none near the end.
  initial begin
    inv.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        inv.ready <= 1'b0;
        repeat (120) @(posedge clk);
        long_hold = 1'b0;
        inv.ready <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        inv.ready <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(posedge clk);
      end else begin
        inv.ready <= 1'b1;
      end
    end
  end

  initial begin
    int drain;
    mat.valid = 1'b0;
    mat.data  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identity, scaled identity, extremes, singular cases.
    send_matrix({16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100});
    send_matrix({16'hFF00, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100});
    send_matrix({16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001});
    send_matrix({16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0, 16'hFFFF});
    send_matrix({16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h7FFF});
    send_matrix({16'h8000, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h8000});
    send_matrix({9{16'h8000}});
    send_matrix({9{16'h7FFF}});
    send_matrix('0);
    send_matrix({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                 16'h8000, 16'h8000, 16'h7FFF});
    send_matrix({16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0100, 16'h0, 16'h0});
    send_matrix({16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0500, 16'h0600,
                 16'h0700, 16'h0800, 16'h0A00});
    send_matrix({16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0500, 16'h0600,
                 16'h0700, 16'h0800, 16'h0900});
    send_matrix({16'h7FFF, 16'h7FFE, 16'h0, 16'h7FFE, 16'h7FFD, 16'h0, 16'h0, 16'h0, 16'h0001});
    send_matrix({16'hFFFF, 16'h8000, 16'h7FFF, 16'h0002, 16'h0001, 16'hFFFE,
                 16'h8000, 16'h0003, 16'h7FFF});

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) long_hold = 1'b1;
      if (i == RANDOM_ITEMS - 200) quiet_phase = 1'b1;
      send_matrix(random_matrix());
    end
    mat.valid <= 1'b0;

    drain = 0;
    while (pending != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
